// File: src/ihc_pkg.sv
// shared types and constants for the ipv4 header checker
package ihc_pkg;

  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] HDR_BYTES   = 5'd20;
  localparam logic [CountW-1:0] IDX_VER_IHL = 5'd0;
  localparam logic [CountW-1:0] IDX_LEN_HI  = 5'd2;
  localparam logic [CountW-1:0] IDX_LEN_LO  = 5'd3;
  localparam logic [CountW-1:0] IDX_PROTO   = 5'd9;
  localparam logic [CountW-1:0] IDX_CSUM_HI = 5'd10;
  localparam logic [CountW-1:0] IDX_CSUM_LO = 5'd11;
  localparam logic [CountW-1:0] IDX_SRC_0   = 5'd12;
  localparam logic [CountW-1:0] IDX_SRC_3   = 5'd15;
  localparam logic [CountW-1:0] IDX_DST_0   = 5'd16;
  localparam logic [CountW-1:0] IDX_DST_3   = 5'd19;

  localparam logic [3:0] VERSION_V4 = 4'd4;
  localparam logic [3:0] IHL_MIN    = 4'd5;
  localparam logic [3:0] IHL_MAX    = 4'd9;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_BAD_HDR = 2'd2,
    STATUS_BAD_SUM = 2'd3
  } ihc_status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] ip_offset;
  } ihc_in_t;

  typedef struct packed {
    ihc_status_e status;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol_number;
    logic [15:0] l4_offset;
    logic [15:0] total_length;
  } ihc_out_t;

endpackage

// File: src/ihc_in_reg.sv
// input register stage holding one byte item
module ihc_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ihc_pkg::ihc_in_t in_item_i,
  input  logic             adv_i,
  output logic             s1_valid_o,
  output ihc_pkg::ihc_in_t s1_item_o
);

  logic             valid_q;
  ihc_pkg::ihc_in_t item_q;
  logic             take;

  assign in_stall_o = valid_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;
  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: src/ihc_hdr_core.sv
// header capture, checksum accumulation and result decision
module ihc_hdr_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  ihc_pkg::ihc_in_t  item_i,
  output logic              res_valid_o,
  output ihc_pkg::ihc_out_t res_o
);

  logic [ihc_pkg::CountW-1:0] cnt_q, cnt_e, cnt_d;
  logic [15:0] sum_q, sum_e, sum_d;
  logic [7:0]  hi_q, hi_e, hi_d;
  logic [7:0]  vi_q, vi_e, vi_d;
  logic [15:0] len_q, len_e, len_d;
  logic [7:0]  pr_q, pr_e, pr_d;
  logic [15:0] st_q, st_e, st_d;
  logic [31:0] src_q, src_e, src_d;
  logic [31:0] dst_q, dst_e, dst_d;
  logic [15:0] off_q, off_e;
  logic        decided_q;

  logic        first, live, is_short;
  logic [7:0]  b;
  logic [16:0] raw_sum;
  logic [3:0]  ver, ihl;

  assign first = item_i.first_byte;
  assign b     = item_i.data_byte;
  assign live  = first || !decided_q;

  // first mark restarts the packet
  assign cnt_e = first ? '0 : cnt_q;
  assign sum_e = first ? '0 : sum_q;
  assign hi_e  = first ? '0 : hi_q;
  assign vi_e  = first ? '0 : vi_q;
  assign len_e = first ? '0 : len_q;
  assign pr_e  = first ? '0 : pr_q;
  assign st_e  = first ? '0 : st_q;
  assign src_e = first ? '0 : src_q;
  assign dst_e = first ? '0 : dst_q;
  assign off_e = first ? item_i.ip_offset : off_q;

  always_comb begin
    vi_d  = vi_e;
    len_d = len_e;
    pr_d  = pr_e;
    st_d  = st_e;
    src_d = src_e;
    dst_d = dst_e;
    case (cnt_e) inside
      ihc_pkg::IDX_VER_IHL:                        vi_d  = b;
      ihc_pkg::IDX_LEN_HI, ihc_pkg::IDX_LEN_LO:    len_d = {len_e[7:0], b};
      ihc_pkg::IDX_PROTO:                          pr_d  = b;
      ihc_pkg::IDX_CSUM_HI, ihc_pkg::IDX_CSUM_LO:  st_d  = {st_e[7:0], b};
      [ihc_pkg::IDX_SRC_0:ihc_pkg::IDX_SRC_3]:     src_d = {src_e[23:0], b};
      [ihc_pkg::IDX_DST_0:ihc_pkg::IDX_DST_3]:     dst_d = {dst_e[23:0], b};
      default: ;
    endcase
  end

  // ones-complement add with end-around carry
  assign raw_sum = {1'b0, sum_e} + {1'b0, hi_e, b};

  always_comb begin
    hi_d  = hi_e;
    sum_d = sum_e;
    if (!cnt_e[0]) begin
      hi_d = b;
    end else if (cnt_e != ihc_pkg::IDX_CSUM_LO) begin
      sum_d = raw_sum[15:0] + {15'd0, raw_sum[16]};
    end
  end

  assign cnt_d = (cnt_e < ihc_pkg::HDR_BYTES) ? cnt_e + 1'b1 : cnt_e;

  assign is_short    = cnt_e < ihc_pkg::IDX_DST_3;
  assign res_valid_o = fire_i && live && (!is_short || item_i.last_byte);

  assign ver = vi_d[7:4];
  assign ihl = vi_d[3:0];

  always_comb begin
    res_o = '0;
    if (is_short) begin
      res_o.status = ihc_pkg::STATUS_SHORT;
    end else begin
      if (ver != ihc_pkg::VERSION_V4 || ihl < ihc_pkg::IHL_MIN || ihl > ihc_pkg::IHL_MAX) begin
        res_o.status = ihc_pkg::STATUS_BAD_HDR;
      end else if (~sum_d != st_d) begin
        res_o.status = ihc_pkg::STATUS_BAD_SUM;
      end else begin
        res_o.status = ihc_pkg::STATUS_OK;
      end
      res_o.source_address  = src_d;
      res_o.dest_address    = dst_d;
      res_o.protocol_number = pr_d;
      res_o.l4_offset       = off_e + {10'd0, ihl, 2'b00};
      res_o.total_length    = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sum_q     <= '0;
      hi_q      <= '0;
      vi_q      <= '0;
      len_q     <= '0;
      pr_q      <= '0;
      st_q      <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      off_q     <= '0;
      decided_q <= 1'b0;
    end else if (fire_i && live) begin
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      hi_q      <= hi_d;
      vi_q      <= vi_d;
      len_q     <= len_d;
      pr_q      <= pr_d;
      st_q      <= st_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
      off_q     <= off_e;
      decided_q <= res_valid_o;
    end
  end

  a_decided_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> decided_q)
    else $error("no decided mark after a result");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ihc_pkg::HDR_BYTES)
    else $error("byte count ran past the base header");

  a_trailing_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decided_q && !item_i.first_byte |-> !res_valid_o)
    else $error("result after the decision without a first mark");

endmodule

// File: src/ihc_out_reg.sv
// result register toward the output channel
module ihc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  ihc_pkg::ihc_out_t res_i,
  output logic              adv_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ihc_pkg::ihc_out_t out_item_o
);

  logic              valid_q;
  ihc_pkg::ihc_out_t item_q;

  assign adv_o       = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      item_q <= res_i;
    end
  end

endmodule

// File: src/ipv4_header_checker_top.sv
// ipv4 header checker top level
//
// Input channel: one packet byte per item, header first, with first and
// last marks; ip_offset is sampled on the first byte.
// Output channel: at most one result item per packet with status,
// addresses, protocol, transport offset and total length.
// A result is produced at the 20th header byte, or at the last byte when
// the packet is shorter; later bytes up to the next first mark are dropped.
// A byte completing a result is held in the input register, the result is
// computed in the logic stage and is on out_valid_o from the result register;
// an output stall can hold that byte in the input register in between.
// Throughput: one byte item per cycle while the output is not stalled; each
// second byte costs one 16-bit end-around-carry add in the single logic stage between the registers.
// Reset clears all header state and the valid flags of both register
// stages; bytes seen before any first mark count as a packet at offset zero.
// When the receiver stalls, the result register holds its item and the
// input stage stalls once it holds a byte too, so nothing is lost.
module ipv4_header_checker_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ihc_pkg::ihc_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ihc_pkg::ihc_out_t out_item_o
);

  logic              adv;
  logic              s1_valid;
  ihc_pkg::ihc_in_t  s1_item;
  logic              res_valid;
  ihc_pkg::ihc_out_t res;

  ihc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  ihc_hdr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_valid && adv),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ihc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && s1_valid |-> in_stall_o)
    else $error("input taken while both stages are full and stalled");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ihc_pkg::STATUS_SHORT
      |-> out_item_o.source_address == '0 && out_item_o.dest_address == '0
          && out_item_o.l4_offset == '0)
    else $error("short packet result carries header fields");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(res_valid))
    else $error("result item without a decision");

endmodule
